// File: rtl/ott_pkg.sv
// Shared types and constants for the one-shot timer table.
package ott_pkg;

   // Request operation codes
   localparam logic [1:0] OP_SCHEDULE = 2'd0;
   localparam logic [1:0] OP_CANCEL   = 2'd1;
   localparam logic [1:0] OP_CHECK    = 2'd2;

   // Reply kind codes
   localparam logic [1:0] KIND_SCHEDULE = 2'd0;
   localparam logic [1:0] KIND_CANCEL   = 2'd1;
   localparam logic [1:0] KIND_FIRED    = 2'd2;
   localparam logic [1:0] KIND_DONE     = 2'd3;

   // Field widths and packed slot layout {deadline, callback, context, id}
   localparam int TIME_W   = 64;
   localparam int HANDLE_W = 32;
   localparam int ID_W     = 32;
   localparam int SLOT_W   = TIME_W + HANDLE_W + HANDLE_W + ID_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINAL
   } ctrl_state_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_SCHED_OK,
      EMIT_SCHED_FAIL,
      EMIT_CANCEL_OK,
      EMIT_CANCEL_FAIL,
      EMIT_FIRED,
      EMIT_DONE
   } emit_type;

   typedef struct packed {
      logic     load;
      logic     advance;
      logic     write_slot;
      logic     set_active;
      logic     clear_active;
      logic     bump_id;
      emit_type emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       eval_valid;
      logic       hit;
      logic       cb_nonzero;
      logic       last_slot;
      logic       out_free;
   } dp_status_type;

endpackage

// File: rtl/ott_ram.sv
// Generic simple dual-port RAM with registered read.
module ott_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ott_datapath.sv
// Datapath: request registers, slot RAM, active bits, id counter, scan and result register.
module ott_datapath #(
   parameter int SLOT_COUNT = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ott_pkg::ctrl_cmd_type     cmd,
   output ott_pkg::dp_status_type    status,
   input  logic [1:0]                req_op,
   input  logic [63:0]               req_deadline,
   input  logic [31:0]               req_callback_handle,
   input  logic [31:0]               req_context_handle,
   input  logic [31:0]               req_cancel_id,
   input  logic [63:0]               req_now_time,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_reply_kind,
   output logic [31:0]               rsp_reply_id,
   output logic [31:0]               rsp_fired_callback,
   output logic [31:0]               rsp_fired_context,
   output logic                      rsp_success,
   output logic                      rsp_last_of_run
);
   import ott_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   // request registers
   logic [1:0]          op_ff;
   logic [TIME_W-1:0]   deadline_ff;
   logic [HANDLE_W-1:0] callback_ff;
   logic [HANDLE_W-1:0] context_ff;
   logic [ID_W-1:0]     cancel_id_ff;
   logic [TIME_W-1:0]   now_ff;

   // table state
   logic [SLOT_COUNT-1:0] active_ff, active_in;
   logic [ID_W-1:0]       next_id_ff, next_id_in;

   // scan pipeline
   logic [CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic             eval_valid_ff, eval_valid_in;
   logic [IDX_W-1:0] eval_idx_ff, eval_idx_in;
   logic             more_reads;
   logic             rd_en;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          kind_ff, kind_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [HANDLE_W-1:0] cb_out_ff, cb_out_in;
   logic [HANDLE_W-1:0] ctx_out_ff, ctx_out_in;
   logic                success_ff, success_in;
   logic                last_ff, last_in;

   // slot RAM read data
   logic [SLOT_W-1:0]   rd_data;
   logic [SLOT_W-1:0]   wr_data;
   logic [TIME_W-1:0]   rd_deadline;
   logic [HANDLE_W-1:0] rd_callback;
   logic [HANDLE_W-1:0] rd_context;
   logic [ID_W-1:0]     rd_id;
   logic                slot_act;
   logic                hit;

   // capture request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_op;
         deadline_ff  <= req_deadline;
         callback_ff  <= req_callback_handle;
         context_ff   <= req_context_handle;
         cancel_id_ff <= req_cancel_id;
         now_ff       <= req_now_time;
      end
   end

   // slot store
   assign wr_data = {deadline_ff, callback_ff, context_ff, next_id_ff};
   assign rd_en   = cmd.advance && more_reads;

   ott_ram #(
      .WIDTH(SLOT_W),
      .DEPTH(SLOT_COUNT)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (cmd.write_slot),
      .wr_addr(eval_idx_ff),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_cnt_ff[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   assign rd_deadline = rd_data[SLOT_W-1 -: TIME_W];
   assign rd_callback = rd_data[HANDLE_W+HANDLE_W+ID_W-1 -: HANDLE_W];
   assign rd_context  = rd_data[HANDLE_W+ID_W-1 -: HANDLE_W];
   assign rd_id       = rd_data[ID_W-1:0];

   // scan address and evaluation stage
   assign more_reads = (rd_cnt_ff < CNT_W'(SLOT_COUNT));

   always_comb begin
      rd_cnt_in     = rd_cnt_ff;
      eval_valid_in = eval_valid_ff;
      eval_idx_in   = eval_idx_ff;
      if (cmd.load) begin
         rd_cnt_in     = '0;
         eval_valid_in = 1'b0;
      end else if (cmd.advance) begin
         eval_valid_in = more_reads;
         if (more_reads) begin
            eval_idx_in = rd_cnt_ff[IDX_W-1:0];
            rd_cnt_in   = rd_cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff     <= '0;
         eval_valid_ff <= 1'b0;
         eval_idx_ff   <= '0;
      end else begin
         rd_cnt_ff     <= rd_cnt_in;
         eval_valid_ff <= eval_valid_in;
         eval_idx_ff   <= eval_idx_in;
      end
   end

   // per-slot decision for the current op
   assign slot_act = active_ff[eval_idx_ff];

   always_comb begin
      case (op_ff)
         OP_SCHEDULE: hit = !slot_act;
         OP_CANCEL:   hit = slot_act && (cancel_id_ff != '0) && (rd_id == cancel_id_ff);
         OP_CHECK:    hit = slot_act && (now_ff >= rd_deadline);
         default:     hit = 1'b0;
      endcase
   end

   // active bits and id counter
   always_comb begin
      active_in = active_ff;
      if (cmd.set_active) begin
         active_in[eval_idx_ff] = 1'b1;
      end
      if (cmd.clear_active) begin
         active_in[eval_idx_ff] = 1'b0;
      end
      next_id_in = next_id_ff;
      if (cmd.bump_id) begin
         next_id_in = next_id_ff + ID_W'(1);
         if (next_id_in == '0) begin
            next_id_in = ID_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= '0;
         next_id_ff <= ID_W'(1);
      end else begin
         active_ff  <= active_in;
         next_id_ff <= next_id_in;
      end
   end

   // result register
   always_comb begin
      kind_in    = kind_ff;
      id_in      = id_ff;
      cb_out_in  = cb_out_ff;
      ctx_out_in = ctx_out_ff;
      success_in = success_ff;
      last_in    = last_ff;
      if (cmd.emit != EMIT_NONE) begin
         id_in      = '0;
         cb_out_in  = '0;
         ctx_out_in = '0;
         success_in = 1'b0;
         last_in    = 1'b1;
      end
      case (cmd.emit)
         EMIT_SCHED_OK: begin
            kind_in    = KIND_SCHEDULE;
            id_in      = next_id_ff;
            success_in = 1'b1;
         end
         EMIT_SCHED_FAIL: begin
            kind_in = KIND_SCHEDULE;
         end
         EMIT_CANCEL_OK: begin
            kind_in    = KIND_CANCEL;
            success_in = 1'b1;
         end
         EMIT_CANCEL_FAIL: begin
            kind_in = KIND_CANCEL;
         end
         EMIT_FIRED: begin
            kind_in    = KIND_FIRED;
            id_in      = rd_id;
            cb_out_in  = rd_callback;
            ctx_out_in = rd_context;
            last_in    = 1'b0;
         end
         EMIT_DONE: begin
            kind_in = KIND_DONE;
         end
         default: begin
         end
      endcase
      if (cmd.emit != EMIT_NONE) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      id_ff      <= id_in;
      cb_out_ff  <= cb_out_in;
      ctx_out_ff <= ctx_out_in;
      success_ff <= success_in;
      last_ff    <= last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reply_kind     = kind_ff;
   assign rsp_reply_id       = id_ff;
   assign rsp_fired_callback = cb_out_ff;
   assign rsp_fired_context  = ctx_out_ff;
   assign rsp_success        = success_ff;
   assign rsp_last_of_run    = last_ff;

   // status to controller
   assign status.op         = op_ff;
   assign status.eval_valid = eval_valid_ff;
   assign status.hit        = hit;
   assign status.cb_nonzero = (rd_callback != '0);
   assign status.last_slot  = (eval_idx_ff == IDX_W'(SLOT_COUNT - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

// File: rtl/ott_ctrl.sv
// Controller: sequences the slot scan and decides table updates and results.
module ott_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_op,
   output logic                   req_ready,
   input  ott_pkg::dp_status_type status,
   output ott_pkg::ctrl_cmd_type  cmd
);
   import ott_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           fire;

   assign fire = status.hit && status.cb_nonzero;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_op == OP_SCHEDULE || req_op == OP_CANCEL ||
                              req_op == OP_CHECK)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.eval_valid) begin
               case (status.op)
                  OP_SCHEDULE, OP_CANCEL: begin
                     if (status.hit) begin
                        if (status.out_free) begin
                           state_in = ST_IDLE;
                        end
                     end else if (status.last_slot) begin
                        state_in = ST_FINAL;
                     end
                  end
                  OP_CHECK: begin
                     if (status.last_slot && (!fire || status.out_free)) begin
                        state_in = ST_FINAL;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FINAL: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // command outputs
   always_comb begin
      req_ready        = 1'b0;
      cmd.load         = 1'b0;
      cmd.advance      = 1'b0;
      cmd.write_slot   = 1'b0;
      cmd.set_active   = 1'b0;
      cmd.clear_active = 1'b0;
      cmd.bump_id      = 1'b0;
      cmd.emit         = EMIT_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            if (!status.eval_valid) begin
               cmd.advance = 1'b1;
            end else begin
               case (status.op)
                  OP_SCHEDULE: begin
                     if (status.hit) begin
                        if (status.out_free) begin
                           cmd.emit       = EMIT_SCHED_OK;
                           cmd.write_slot = 1'b1;
                           cmd.set_active = 1'b1;
                           cmd.bump_id    = 1'b1;
                        end
                     end else if (!status.last_slot) begin
                        cmd.advance = 1'b1;
                     end
                  end
                  OP_CANCEL: begin
                     if (status.hit) begin
                        if (status.out_free) begin
                           cmd.emit         = EMIT_CANCEL_OK;
                           cmd.clear_active = 1'b1;
                        end
                     end else if (!status.last_slot) begin
                        cmd.advance = 1'b1;
                     end
                  end
                  OP_CHECK: begin
                     // a firing slot waits for the result register
                     if (fire) begin
                        if (status.out_free) begin
                           cmd.emit         = EMIT_FIRED;
                           cmd.clear_active = 1'b1;
                           cmd.advance      = 1'b1;
                        end
                     end else begin
                        cmd.clear_active = status.hit;
                        cmd.advance      = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FINAL: begin
            if (status.out_free) begin
               case (status.op)
                  OP_SCHEDULE: cmd.emit = EMIT_SCHED_FAIL;
                  OP_CANCEL:   cmd.emit = EMIT_CANCEL_FAIL;
                  OP_CHECK:    cmd.emit = EMIT_DONE;
                  default:     cmd.emit = EMIT_NONE;
               endcase
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// File: rtl/oneshot_timer_table_unit.sv
// Top level: one-shot timer table of SLOT_COUNT slots with sequential slot scan.
// A request scans the slots one per cycle through the slot RAM read port, except while a
// result waits for rsp_ready; schedule and cancel finish at the first matching slot.
// A check scans every slot, and its results also wait for rsp_ready.
// One request is handled at a time; op 3 is dropped.
// Reset clears the active bits and the result valid flag and sets the next id to 1;
// slot RAM contents are not cleared and are used only for active slots.
module oneshot_timer_table_unit #(
   parameter int SLOT_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_deadline,
   input  logic [31:0] req_callback_handle,
   input  logic [31:0] req_context_handle,
   input  logic [31:0] req_cancel_id,
   input  logic [63:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_reply_kind,
   output logic [31:0] rsp_reply_id,
   output logic [31:0] rsp_fired_callback,
   output logic [31:0] rsp_fired_context,
   output logic        rsp_success,
   output logic        rsp_last_of_run
);
   import ott_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   ott_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_op   (req_op),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   ott_datapath #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_op),
      .req_deadline       (req_deadline),
      .req_callback_handle(req_callback_handle),
      .req_context_handle (req_context_handle),
      .req_cancel_id      (req_cancel_id),
      .req_now_time       (req_now_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_reply_kind     (rsp_reply_kind),
      .rsp_reply_id       (rsp_reply_id),
      .rsp_fired_callback (rsp_fired_callback),
      .rsp_fired_context  (rsp_fired_context),
      .rsp_success        (rsp_success),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   // a new result never overwrites one still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit != EMIT_NONE) |-> status.out_free)
      else $error("result issued while result register busy");

   // a successful schedule shows up as a final, successful reply
   a_sched_reply: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit == EMIT_SCHED_OK) |=> (rsp_valid && rsp_success && rsp_last_of_run))
      else $error("schedule reply malformed");

   // an assigned id is never zero
   a_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reply_kind == KIND_SCHEDULE && rsp_success) |-> (rsp_reply_id != '0))
      else $error("schedule handed out id zero");

   // fired results carry a callback and are never last
   a_fired_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reply_kind == KIND_FIRED) |->
         (!rsp_last_of_run && rsp_fired_callback != '0))
      else $error("fired result malformed");

endmodule

// File: dv/tb_oneshot_timer_table_unit.sv
// Self-checking testbench for the one-shot timer table unit.
module tb_oneshot_timer_table_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ott_pkg::*;

   localparam int SLOTS          = 16;
   localparam int CYCLE_LIMIT    = 300000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 2 * (SLOTS + 3);
   localparam int RANDOM_ITEMS   = 150;
   localparam logic [1:0]  OP_UNUSED = 2'd3;
   localparam logic [63:0] TIME_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;

   // One reply as the block should present it
   typedef struct {
      logic [1:0]  kind;
      logic [31:0] id;
      logic [31:0] callback;
      logic [31:0] context_tag;
      logic        success;
      logic        last;
   } timer_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = OP_SCHEDULE;
   logic [63:0] req_deadline = '0;
   logic [31:0] req_callback_handle = '0;
   logic [31:0] req_context_handle = '0;
   logic [31:0] req_cancel_id = '0;
   logic [63:0] req_now_time = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_reply_kind;
   logic [31:0] rsp_reply_id;
   logic [31:0] rsp_fired_callback;
   logic [31:0] rsp_fired_context;
   logic        rsp_success;
   logic        rsp_last_of_run;

   // Shadow copy of the timer table
   logic        shadow_active [SLOTS];
   logic [63:0] shadow_deadline [SLOTS];
   logic [31:0] shadow_callback [SLOTS];
   logic [31:0] shadow_context [SLOTS];
   logic [31:0] shadow_id [SLOTS];
   logic [31:0] shadow_next_id;

   timer_reply_type pending_replies[$];
   int mismatch_count = 0;
   int cycle_count = 0;

   // Sender pacing
   int burst_left = 0;
   bit sender_no_gaps = 1'b0;

   // Receiver pacing
   int holdoff_trigger = 0;
   int holdoff_seen = 0;
   int holdoff_left = 0;
   int ready_mode = 0;
   int mode_left = 0;
   logic [7:0] stall_pattern = 8'hA5;

   oneshot_timer_table_unit #(
      .SLOT_COUNT(SLOTS)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_deadline       (req_deadline),
      .req_callback_handle(req_callback_handle),
      .req_context_handle (req_context_handle),
      .req_cancel_id      (req_cancel_id),
      .req_now_time       (req_now_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_reply_kind     (rsp_reply_kind),
      .rsp_reply_id       (rsp_reply_id),
      .rsp_fired_callback (rsp_fired_callback),
      .rsp_fired_context  (rsp_fired_context),
      .rsp_success        (rsp_success),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   always #5 clock = ~clock;

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_oneshot_timer_table_unit: errors");
      $finish;
   end

   function automatic void push_reply(input logic [1:0] kind, input logic [31:0] id,
                                      input logic [31:0] callback, input logic [31:0] ctx,
                                      input logic success, input logic last);
      timer_reply_type r;
      r.kind        = kind;
      r.id          = id;
      r.callback    = callback;
      r.context_tag = ctx;
      r.success     = success;
      r.last        = last;
      pending_replies.push_back(r);
   endfunction

   function automatic void clear_shadow_table();
      for (int i = 0; i < SLOTS; i++) begin
         shadow_active[i]   = 1'b0;
         shadow_deadline[i] = '0;
         shadow_callback[i] = '0;
         shadow_context[i]  = '0;
         shadow_id[i]       = '0;
      end
      shadow_next_id = 32'd1;
   endfunction

   // Update the shadow table for one accepted request and queue its replies
   function automatic void predict_timer_replies(input logic [1:0] op,
                                                 input logic [63:0] deadline,
                                                 input logic [31:0] callback,
                                                 input logic [31:0] ctx,
                                                 input logic [31:0] cancel_id,
                                                 input logic [63:0] check_time);
      bit found;
      found = 1'b0;
      case (op)
         OP_SCHEDULE: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!found && !shadow_active[i]) begin
                  found              = 1'b1;
                  shadow_deadline[i] = deadline;
                  shadow_callback[i] = callback;
                  shadow_context[i]  = ctx;
                  shadow_id[i]       = shadow_next_id;
                  shadow_active[i]   = 1'b1;
                  push_reply(KIND_SCHEDULE, shadow_next_id, '0, '0, 1'b1, 1'b1);
                  shadow_next_id = shadow_next_id + 32'd1;
                  if (shadow_next_id == 32'd0) shadow_next_id = 32'd1;
               end
            end
            if (!found) push_reply(KIND_SCHEDULE, '0, '0, '0, 1'b0, 1'b1);
         end
         OP_CANCEL: begin
            if (cancel_id != 32'd0) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (!found && shadow_active[i] && shadow_id[i] == cancel_id) begin
                     found            = 1'b1;
                     shadow_active[i] = 1'b0;
                  end
               end
            end
            push_reply(KIND_CANCEL, '0, '0, '0, found, 1'b1);
         end
         OP_CHECK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (shadow_active[i] && check_time >= shadow_deadline[i]) begin
                  shadow_active[i] = 1'b0;
                  if (shadow_callback[i] != 32'd0)
                     push_reply(KIND_FIRED, shadow_id[i], shadow_callback[i],
                                shadow_context[i], 1'b0, 1'b0);
               end
            end
            push_reply(KIND_DONE, '0, '0, '0, 1'b0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   // Offer one request, with burst and gap pacing, and predict on acceptance
   task automatic send_request(input logic [1:0] op, input logic [63:0] deadline,
                               input logic [31:0] callback, input logic [31:0] ctx,
                               input logic [31:0] cancel_id, input logic [63:0] check_time);
      int gap;
      if (!sender_no_gaps && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 10);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_valid           <= 1'b1;
      req_op              <= op;
      req_deadline        <= deadline;
      req_callback_handle <= callback;
      req_context_handle  <= ctx;
      req_cancel_id       <= cancel_id;
      req_now_time        <= check_time;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_timer_replies(op, deadline, callback, ctx, cancel_id, check_time);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   // Check every reply transaction against the oldest prediction
   always @(posedge clock) begin
      timer_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: unexpected reply, expected none actual kind %0d id %0h",
                     $time, rsp_reply_kind, rsp_reply_id);
         end else begin
            want = pending_replies.pop_front();
            compare_field("reply_kind", 64'(want.kind), 64'(rsp_reply_kind));
            compare_field("reply_id", 64'(want.id), 64'(rsp_reply_id));
            compare_field("fired_callback", 64'(want.callback), 64'(rsp_fired_callback));
            compare_field("fired_context", 64'(want.context_tag), 64'(rsp_fired_context));
            compare_field("success", 64'(want.success), 64'(rsp_success));
            compare_field("last_of_run", 64'(want.last), 64'(rsp_last_of_run));
         end
      end
   end

   // Receiver: changing stall patterns plus an occasional long hold-off
   always @(negedge clock) begin
      if (holdoff_trigger != holdoff_seen) begin
         holdoff_seen = holdoff_trigger;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (mode_left == 0) begin
         ready_mode    = $urandom_range(0, 3);
         mode_left     = $urandom_range(8, 60);
         stall_pattern = 8'($urandom());
      end
      mode_left--;
      stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= stall_pattern[0];
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Unknown op, zero cancel id and a check on an empty table
   task automatic test_ignored_and_empty();
      send_request(OP_UNUSED, TIME_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TIME_MAX);
      send_request(OP_CANCEL, '0, '0, '0, 32'd0, '0);
      send_request(OP_CHECK, '0, '0, '0, '0, 64'd0);
   endtask

   // Fill every slot, field extremes in the first two, then overflow the table
   task automatic test_fill_table();
      send_request(OP_SCHEDULE, 64'd0, 32'd0, 32'd0, '0, '0);
      send_request(OP_SCHEDULE, TIME_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
      for (int i = 2; i < SLOTS; i++)
         send_request(OP_SCHEDULE, 64'(i * 100), 32'h1000_0000 + 32'(i),
                      32'hC0DE_0000 + 32'(i), '0, '0);
      send_request(OP_SCHEDULE, 64'd123, 32'hDEAD_BEEF, 32'h5555_AAAA, '0, '0);
   endtask

   // Cancel a live id, then the same id again
   task automatic test_cancel();
      send_request(OP_CANCEL, '0, '0, '0, 32'd2, '0);
      send_request(OP_CANCEL, '0, '0, '0, 32'd2, '0);
   endtask

   // Deadline equal to the check time fires; zero callback expires silently
   task automatic test_expiry();
      send_request(OP_CHECK, '0, '0, '0, '0, 64'd500);
      send_request(OP_CHECK, '0, '0, '0, '0, TIME_MAX);
   endtask

   // Mostly deadlines and check times in one window so checks fire part of the table
   task automatic test_random_traffic();
      logic [63:0] window_base;
      logic [63:0] deadline;
      logic [63:0] check_time;
      logic [31:0] callback;
      logic [31:0] cancel_id;
      logic [31:0] live_ids[$];
      int counted;
      int pick;
      window_base = rand64();
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         deadline = ($urandom_range(0, 4) == 0) ? rand64()
                                                : window_base + $urandom_range(0, 1000);
         case ($urandom_range(0, 9))
            0: check_time = rand64();
            1: check_time = $urandom_range(0, 1) ? TIME_MAX : 64'd0;
            default: check_time = window_base + $urandom_range(0, 1200);
         endcase
         callback = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom();
         live_ids.delete();
         for (int i = 0; i < SLOTS; i++)
            if (shadow_active[i]) live_ids.push_back(shadow_id[i]);
         case ($urandom_range(0, 19))
            0, 1: cancel_id = 32'd0;
            2, 3, 4: cancel_id = $urandom();
            5, 6, 7: cancel_id = $urandom_range(1, (shadow_next_id > 1) ? shadow_next_id - 1 : 1);
            default: cancel_id = (live_ids.size() > 0)
                                 ? live_ids[$urandom_range(0, live_ids.size() - 1)]
                                 : $urandom();
         endcase
         if (pick < 40) begin
            send_request(OP_SCHEDULE, deadline, callback, $urandom(), $urandom(), rand64());
            counted++;
         end else if (pick < 65) begin
            send_request(OP_CANCEL, rand64(), $urandom(), $urandom(), cancel_id, rand64());
            counted++;
         end else if (pick < 92) begin
            send_request(OP_CHECK, rand64(), $urandom(), $urandom(), $urandom(), check_time);
            counted++;
         end else begin
            send_request(OP_UNUSED, deadline, callback, $urandom(), cancel_id, check_time);
         end
      end
   endtask

   // Receiver holds off while the sender keeps offering; ends on a full 17-reply check
   task automatic test_backpressure();
      send_request(OP_CHECK, '0, '0, '0, '0, TIME_MAX);
      sender_no_gaps = 1'b1;
      holdoff_trigger++;
      for (int i = 0; i < SLOTS; i++)
         send_request(OP_SCHEDULE, 64'($urandom_range(0, 50)), $urandom() | 32'd1,
                      $urandom(), $urandom(), rand64());
      send_request(OP_CHECK, rand64(), $urandom(), $urandom(), $urandom(), TIME_MAX);
      sender_no_gaps = 1'b0;
   endtask

   initial begin
      clear_shadow_table();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_ignored_and_empty();
      test_fill_table();
      test_cancel();
      test_expiry();
      test_random_traffic();
      test_backpressure();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb_oneshot_timer_table_unit: clean");
      end else begin
         $display("tb_oneshot_timer_table_unit: errors");
      end
      $finish;
   end

endmodule
